/* rtl/lcdi2c_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdi2c_pkg
// Shared types and constants for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdi2c_pkg;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;
  localparam logic [1:0] KIND_NUMBER = 2'd3;

  localparam logic [1:0] ROW_FIRST  = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;

  localparam logic [7:0] NIB_MASK  = 8'hF0;
  localparam logic [7:0] CMD_E_HI  = 8'h0C;
  localparam logic [7:0] CMD_E_LO  = 8'h08;
  localparam logic [7:0] DAT_E_HI  = 8'h0D;
  localparam logic [7:0] DAT_E_LO  = 8'h09;
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ASCII_0   = 8'h30;
  localparam logic [6:0] ADDR_RESET = 7'h27;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       last;
  } lcd_word_t;

endpackage

/* rtl/lcdi2c_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdi2c_front
// Accepts requests, builds LCD command/data words and converts numbers to
// decimal digits, one digit per cycle, then queues them most significant first.
// ----------------------------------------------------------------------------
module lcdi2c_front import lcdi2c_pkg::*; #(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_value,
  input  logic [1:0]  in_cursor_row,
  input  logic [6:0]  in_cursor_column,
  input  logic [2:0]  in_min_digits,
  output logic        push_valid,
  output lcd_word_t   push_word,
  input  logic        q_full
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [15:0]      v_r, v_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] nd_r, nd_nxt;
  logic [2:0]       mind_r, mind_nxt;
  logic [3:0]       digs_r [MAX_DIGITS];

  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot10;
  logic [3:0]  digit;
  logic [2:0]  mind_c;
  logic [2:0]  nd3;
  logic [2:0]  ndig;
  logic [7:0]  cur_col;
  logic        dig_we;

  assign prod    = 32'(v_r) * DIV10_MUL;
  assign quot    = prod[DIV10_SHIFT +: 13];
  assign quot10  = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
  assign digit   = 4'(v_r - quot10);
  assign mind_c  = (mind_r > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : mind_r;
  assign nd3     = 3'(nd_r);
  assign ndig    = (nd3 > mind_c) ? nd3 : mind_c;
  assign cur_col = {1'b0, in_cursor_column} - 8'd1;
  assign dig_we  = (state_r == ST_DIV);
  assign in_ready = (state_r == ST_IDLE) && !q_full;

  always_comb begin
    state_nxt  = state_r;
    v_nxt      = v_r;
    cnt_nxt    = cnt_r;
    nd_nxt     = nd_r;
    mind_nxt   = mind_r;
    push_valid = 1'b0;
    push_word  = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_kind)
            KIND_CMD: begin
              push_valid = 1'b1;
              push_word  = '{data: in_value[7:0], rs: 1'b0, last: 1'b1};
            end
            KIND_DATA: begin
              push_valid = 1'b1;
              push_word  = '{data: in_value[7:0], rs: 1'b1, last: 1'b1};
            end
            KIND_CURSOR: begin
              if (in_cursor_row == ROW_FIRST) begin
                push_valid = 1'b1;
                push_word  = '{data: cur_col | ROW1_BASE, rs: 1'b0, last: 1'b1};
              end else if (in_cursor_row == ROW_SECOND) begin
                push_valid = 1'b1;
                push_word  = '{data: cur_col | ROW2_BASE, rs: 1'b0, last: 1'b1};
              end
            end
            default: begin
              state_nxt = ST_DIV;
              v_nxt     = in_value;
              cnt_nxt   = '0;
              nd_nxt    = CNT_W'(1);
              mind_nxt  = in_min_digits;
            end
          endcase
        end
      end
      ST_DIV: begin
        v_nxt = 16'(quot);
        if (cnt_r != IDX_LAST && quot != '0) begin
          nd_nxt = nd_r + CNT_W'(1);
        end
        if (cnt_r == IDX_LAST) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = IDX_W'(ndig - 3'd1);
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (!q_full) begin
          push_valid = 1'b1;
          push_word  = '{data: 8'(digs_r[cnt_r]) + ASCII_0, rs: 1'b1,
                         last: (cnt_r == '0)};
          if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    v_r    <= v_nxt;
    cnt_r  <= cnt_nxt;
    nd_r   <= nd_nxt;
    mind_r <= mind_nxt;
    if (dig_we) begin
      digs_r[cnt_r] <= digit;
    end
  end

endmodule

/* rtl/lcdi2c_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdi2c_queue
// Two-entry queue of LCD words between the front and back ends.
// ----------------------------------------------------------------------------
module lcdi2c_queue import lcdi2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  lcd_word_t push_word,
  output logic      full,
  input  logic      pop,
  output lcd_word_t head,
  output logic      empty
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  lcd_word_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == CNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* rtl/lcdi2c_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdi2c_back
// Splits each queued LCD word into four expander words (two nibbles, each with
// enable strobed high then low) behind a registered output stage.
// ----------------------------------------------------------------------------
module lcdi2c_back import lcdi2c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lcd_word_t  head,
  input  logic       q_empty,
  output logic       pop,
  input  logic [6:0] expander_address,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_bus_address,
  output logic [7:0] out_expander_byte,
  output logic       out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] bus_addr_r;
  logic [7:0] exp_byte_r;
  logic       last_r;
  logic [1:0] ph_r, ph_nxt;
  logic       load;
  logic [3:0] nib;
  logic [7:0] ctl;
  logic [7:0] exp_byte_c;

  assign load = (!out_valid_r || out_ready) && !q_empty;
  assign pop  = load && (ph_r == 2'd3);
  assign nib  = ph_r[1] ? head.data[3:0] : head.data[7:4];
  assign ctl  = ph_r[0] ? (head.rs ? DAT_E_LO : CMD_E_LO)
                        : (head.rs ? DAT_E_HI : CMD_E_HI);
  assign exp_byte_c = ({nib, 4'b0000} & NIB_MASK) | ctl;

  always_comb begin
    out_valid_nxt = out_valid_r;
    ph_nxt        = ph_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      ph_nxt        = ph_r + 2'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ph_r        <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
    end
    if (load) begin
      bus_addr_r <= {expander_address, 1'b0};
      exp_byte_r <= exp_byte_c;
      last_r     <= head.last && (ph_r == 2'd3);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bus_address   = bus_addr_r;
  assign out_expander_byte = exp_byte_r;
  assign out_last          = last_r;

endmodule

/* rtl/char_lcd_i2c_nibble_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_i2c_nibble_sequencer
// Turns character LCD requests into port-expander words for a 4-bit LCD.
// ----------------------------------------------------------------------------
// Input channel (in_*): one request per word - command, data byte, cursor
// position or decimal number. Output channel (out_*): one expander word per
// handshake, with the I2C write address alongside and out_last on the final
// word of each request. cfg_* writes the 7-bit expander address; it is always
// ready and should only be written while the block is idle.
// Each LCD byte gives four output words, one per cycle when out_ready is high,
// so throughput is set by the back end. A number first runs through the
// divide-by-ten step, then emits up to MAX_DIGITS bytes: up to 4 * MAX_DIGITS
// output words. Words reach out_valid through the queue and the output
// register; a cursor request whose row is not 1 or 2 gives no words.
// A two-word queue sits between the request side and the output side, so new
// requests are taken while earlier words wait; a stalled receiver holds the
// output register and back-pressures through the queue to in_ready.
// Reset clears all control state and sets the address to 0x27.
// ----------------------------------------------------------------------------
module char_lcd_i2c_nibble_sequencer import lcdi2c_pkg::*; #(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_expander_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_value,
  input  logic [1:0]  in_cursor_row,
  input  logic [6:0]  in_cursor_column,
  input  logic [2:0]  in_min_digits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_bus_address,
  output logic [7:0]  out_expander_byte,
  output logic        out_last
);

  logic [6:0] addr_r, addr_nxt;
  logic       push_valid;
  lcd_word_t  push_word;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  lcd_word_t  q_head;

  assign cfg_ready = 1'b1;
  assign addr_nxt  = (cfg_valid && cfg_ready) ? cfg_expander_address : addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  lcdi2c_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .in_cursor_row    (in_cursor_row),
    .in_cursor_column (in_cursor_column),
    .in_min_digits    (in_min_digits),
    .push_valid       (push_valid),
    .push_word        (push_word),
    .q_full           (q_full)
  );

  lcdi2c_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  lcdi2c_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_empty           (q_empty),
    .pop               (q_pop),
    .expander_address  (addr_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bus_address   (out_bus_address),
    .out_expander_byte (out_expander_byte),
    .out_last          (out_last)
  );

endmodule

/* tb/char_lcd_i2c_nibble_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_i2c_nibble_sequencer_tb
// Self-checking bench for the LCD nibble sequencer behind an I2C expander.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel. Each one accepted is expanded
// here into the expander words it should produce. Every word that comes out
// is checked field by field against the oldest word still owed. Directed
// requests cover field extremes and the corner cases; random traffic then runs
// with more receiver idling, then more sender idling, then none. The expander
// address is rewritten between phases, a long receiver stall fills the block,
// and the sender pauses until the block is empty.
// ----------------------------------------------------------------------------
module char_lcd_i2c_nibble_sequencer_tb import lcdi2c_pkg::*; ();

  localparam int MAX_DIGITS  = 5;
  localparam int SETTLE_CYC  = 40;
  localparam int MAX_REPORTS = 20;
  localparam int LIMIT_NS    = 4_000_000;

  typedef struct packed {
    logic [7:0] bus_address;
    logic [7:0] expander_byte;
    logic       last;
  } expander_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_expander_address;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [15:0] in_value;
  logic [1:0]  in_cursor_row;
  logic [6:0]  in_cursor_column;
  logic [2:0]  in_min_digits;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_bus_address;
  logic [7:0]  out_expander_byte;
  logic        out_last;

  expander_word_t pending_words[$];
  logic [6:0]     expander_addr;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             long_stall_cycles;
  int             mismatches;
  int             requests_sent;
  int             words_checked;
  int             addr_writes;

  char_lcd_i2c_nibble_sequencer #(
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_expander_address(cfg_expander_address),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_value            (in_value),
    .in_cursor_row       (in_cursor_row),
    .in_cursor_column    (in_cursor_column),
    .in_min_digits       (in_min_digits),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bus_address     (out_bus_address),
    .out_expander_byte   (out_expander_byte),
    .out_last            (out_last)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS)
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // four expander words per LCD byte: high nibble E up/down, then low nibble
  function automatic void owe_lcd_byte(input logic [7:0] lcd_byte, input logic rs,
                                       input logic fin);
    logic [7:0]     hi;
    logic [7:0]     lo;
    logic [7:0]     e_on;
    logic [7:0]     e_off;
    expander_word_t w;
    hi    = lcd_byte & NIB_MASK;
    lo    = {lcd_byte[3:0], 4'h0};
    e_on  = rs ? DAT_E_HI : CMD_E_HI;
    e_off = rs ? DAT_E_LO : CMD_E_LO;
    w.bus_address   = {expander_addr, 1'b0};
    w.last          = 1'b0;
    w.expander_byte = hi | e_on;
    pending_words.push_back(w);
    w.expander_byte = hi | e_off;
    pending_words.push_back(w);
    w.expander_byte = lo | e_on;
    pending_words.push_back(w);
    w.expander_byte = lo | e_off;
    w.last          = fin;
    pending_words.push_back(w);
  endfunction

  function automatic void owe_request_words(input logic [1:0] kind, input logic [15:0] value,
                                            input logic [1:0] row, input logic [6:0] col,
                                            input logic [2:0] mind);
    logic [7:0] pos;
    logic [3:0] digits[MAX_DIGITS];
    int         v;
    int         n;
    int         want;
    pos = {1'b0, col} - 8'd1;
    case (kind)
      KIND_CMD:  owe_lcd_byte(value[7:0], 1'b0, 1'b1);
      KIND_DATA: owe_lcd_byte(value[7:0], 1'b1, 1'b1);
      KIND_CURSOR: begin
        if (row == ROW_FIRST)
          owe_lcd_byte(pos | ROW1_BASE, 1'b0, 1'b1);
        else if (row == ROW_SECOND)
          owe_lcd_byte(pos | ROW2_BASE, 1'b0, 1'b1);
      end
      default: begin
        v = value;
        for (int i = 0; i < MAX_DIGITS; i++) begin
          digits[i] = 4'(v % 10);
          v = v / 10;
        end
        n = 0;
        v = value;
        do begin
          n++;
          v = v / 10;
        end while (v > 0 && n < MAX_DIGITS);
        want = (int'(mind) > MAX_DIGITS) ? MAX_DIGITS : int'(mind);
        if (want > n)
          n = want;
        for (int i = n - 1; i >= 0; i--)
          owe_lcd_byte(ASCII_0 + {4'h0, digits[i]}, 1'b1, i == 0);
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_words
    expander_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_expander_byte, 0);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_bus_address !== want.bus_address)
          report_mismatch("bus_address", out_bus_address, want.bus_address);
        if (out_expander_byte !== want.expander_byte)
          report_mismatch("expander_byte", out_expander_byte, want.expander_byte);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  always @(negedge clk) begin
    if (long_stall_cycles > 0) begin
      out_ready <= 1'b0;
      long_stall_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [15:0] value,
                              input logic [1:0] row, input logic [6:0] col,
                              input logic [2:0] mind);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_value         <= value;
    in_cursor_row    <= row;
    in_cursor_column <= col;
    in_min_digits    <= mind;
    do @(posedge clk); while (!in_ready);
    owe_request_words(kind, value, row, col, mind);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_address(input logic [6:0] addr);
    cfg_valid            <= 1'b1;
    cfg_expander_address <= addr;
    do @(posedge clk); while (!cfg_ready);
    expander_addr = addr;
    addr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    logic [1:0]  kind;
    logic [15:0] value;
    logic [1:0]  row;
    kind  = 2'($urandom_range(0, 3));
    value = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 120)) : 16'($urandom);
    row   = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) :
            (($urandom_range(0, 1) == 0) ? ROW_FIRST : ROW_SECOND);
    send_request(kind, value, row, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
  endtask

  task automatic test_directed_requests();
    send_request(KIND_CMD,    16'h0000, 2'd0, 7'd0,   3'd0);
    send_request(KIND_CMD,    16'h00FF, 2'd3, 7'd127, 3'd7);
    send_request(KIND_CMD,    16'hAB5A, 2'd1, 7'd5,   3'd2);
    send_request(KIND_DATA,   16'h0000, 2'd0, 7'd0,   3'd0);
    send_request(KIND_DATA,   16'hFFFF, 2'd3, 7'd127, 3'd7);
    send_request(KIND_DATA,   16'h1241, 2'd2, 7'd1,   3'd1);
    send_request(KIND_CURSOR, 16'h0000, ROW_FIRST,  7'd1,   3'd0);
    send_request(KIND_CURSOR, 16'hFFFF, ROW_SECOND, 7'd127, 3'd7);
    send_request(KIND_CURSOR, 16'h0000, ROW_FIRST,  7'd0,   3'd0);
    send_request(KIND_CURSOR, 16'h0000, ROW_SECOND, 7'd0,   3'd0);
    send_request(KIND_CURSOR, 16'h1234, 2'd0,       7'd9,   3'd0);
    send_request(KIND_CURSOR, 16'h1234, 2'd3,       7'd9,   3'd0);
    send_request(KIND_CURSOR, 16'h0000, ROW_SECOND, 7'd40,  3'd0);
    send_request(KIND_NUMBER, 16'd0,     2'd0, 7'd0,   3'd0);
    send_request(KIND_NUMBER, 16'd0,     2'd0, 7'd0,   3'd5);
    send_request(KIND_NUMBER, 16'd65535, 2'd3, 7'd127, 3'd0);
    send_request(KIND_NUMBER, 16'd7,     2'd0, 7'd0,   3'd7);
    send_request(KIND_NUMBER, 16'd9,     2'd0, 7'd0,   3'd6);
    send_request(KIND_NUMBER, 16'd12345, 2'd1, 7'd3,   3'd3);
    send_request(KIND_NUMBER, 16'd100,   2'd0, 7'd0,   3'd2);
    send_request(KIND_NUMBER, 16'd10000, 2'd0, 7'd0,   3'd1);
    send_request(KIND_NUMBER, 16'd42,    2'd2, 7'd64,  3'd4);
    wait_idle();
  endtask

  task automatic test_address_extremes();
    write_address(7'h00);
    send_request(KIND_CMD, 16'h0033, 2'd0, 7'd0, 3'd0);
    send_request(KIND_NUMBER, 16'd907, 2'd0, 7'd0, 3'd0);
    wait_idle();
    write_address(7'h7F);
    send_request(KIND_DATA, 16'h00C5, 2'd0, 7'd0, 3'd0);
    send_request(KIND_CURSOR, 16'h0000, ROW_SECOND, 7'd16, 3'd0);
    wait_idle();
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int count,
                                   input logic [6:0] addr);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    write_address(addr);
    repeat (count) send_random_request();
    wait_idle();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    long_stall_cycles = 400;
    repeat (14) send_random_request();
    wait_idle();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_idle_pct = 37;
    repeat (6) send_random_request();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (6) send_random_request();
    wait_idle();
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_valid            = 1'b0;
    cfg_expander_address = 7'h00;
    in_valid             = 1'b0;
    in_kind              = KIND_CMD;
    in_value             = 16'h0000;
    in_cursor_row        = 2'd0;
    in_cursor_column     = 7'd0;
    in_min_digits        = 3'd0;
    out_ready            = 1'b0;
    expander_addr        = ADDR_RESET;
    send_idle_pct        = 37;
    recv_idle_pct        = 69;
    long_stall_cycles    = 0;
    mismatches           = 0;
    requests_sent        = 0;
    words_checked        = 0;
    addr_writes          = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_requests();
    test_address_extremes();
    test_random_phase(37, 69, 100, 7'($urandom_range(0, 127)));
    test_random_phase(69, 37, 100, 7'($urandom_range(0, 127)));
    test_random_phase(0, 0, 100, ADDR_RESET);
    test_receiver_stall();
    test_sender_pause();

    if (pending_words.size() != 0)
      report_mismatch("words never produced", 0, pending_words.size());
    $display("Covered %0d requests, %0d expander words, %0d address writes, with idling,",
             requests_sent, words_checked, addr_writes);
    $display("a long output stall and a drained pause; %0d mismatches.", mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/lcdi2c_pkg.sv
rtl/lcdi2c_front.sv
rtl/lcdi2c_queue.sv
rtl/lcdi2c_back.sv
rtl/char_lcd_i2c_nibble_sequencer.sv
tb/char_lcd_i2c_nibble_sequencer_tb.sv
